// ===== hdl/cc20_pkg.sv =====
package cc20_pkg;

	localparam int unsigned DOUBLE_ROUNDS_DEF = 10;
	localparam int unsigned CFG_W = 64;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned WORD_W = 32;

	localparam logic [3:0][WORD_W-1:0] SIGMA = {
		32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
	};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_01   = 3'd0,
		REG_KEY_23   = 3'd1,
		REG_KEY_45   = 3'd2,
		REG_KEY_67   = 3'd3,
		REG_NONCE_01 = 3'd4,
		REG_NONCE_2  = 3'd5,
		REG_INIT_CTR = 3'd6
	} cfg_idx_t;

	typedef struct packed {
		logic [WORD_W-1:0] data_in;
		logic              last_word;
	} in_item_t;

	typedef struct packed {
		logic [WORD_W-1:0] data_out;
		logic              last_out;
	} out_item_t;

	typedef struct packed {
		logic [7:0][WORD_W-1:0] key;
		logic [2:0][WORD_W-1:0] nonce;
		logic [WORD_W-1:0]      init_ctr;
	} cfg_t;

	typedef logic [15:0][WORD_W-1:0] block_t;

	function automatic block_t init_state(input cfg_t cfg, input logic [WORD_W-1:0] ctr);
		block_t s;
		s[3:0]   = SIGMA;
		s[11:4]  = cfg.key;
		s[12]    = ctr;
		s[15:13] = cfg.nonce;
		return s;
	endfunction

endpackage

// ===== hdl/chacha20_stream_xor.sv =====
// words 1..15 of a block use the keystream already held and are valid in the cycle after they are taken
// the first word of a block waits for its keystream block: ST_ROUND, then ST_FINAL, then ST_OUT
// no input word is taken while a keystream block is computed, at one four-lane round step per cycle
// one round step unit, reused for every step of every double round
// arst_n clears all config registers, block counter, word position and handshake state
module chacha20_stream_xor #(
	parameter int unsigned DOUBLE_ROUNDS = cc20_pkg::DOUBLE_ROUNDS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  cc20_pkg::in_item_t                 in_item,
	output logic                               out_valid,
	input  logic                               out_stall,
	output cc20_pkg::out_item_t                out_item,
	input  logic                               cfg_we,
	input  logic [cc20_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [cc20_pkg::CFG_W-1:0]         cfg_data
);

	localparam int unsigned DR_W = (DOUBLE_ROUNDS > 1) ? $clog2(DOUBLE_ROUNDS) : 1;
	localparam int unsigned W = cc20_pkg::WORD_W;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROUND,
		ST_FINAL,
		ST_OUT
	} state_t;

	state_t                 state_q;
	logic [2:0]             step_q;
	logic [DR_W-1:0]        dr_q;
	logic [3:0]             pos_q;
	logic                   msg_start_q;
	logic [W-1:0]           blk_ctr_q;
	logic [W-1:0]           ctr_q;
	logic [W-1:0]           data_q;
	logic                   last_q;
	logic                   out_valid_q;
	cc20_pkg::out_item_t    out_item_q;
	cc20_pkg::block_t       w_q;

	cc20_pkg::cfg_t         cfg;
	cc20_pkg::block_t       w_rnd;
	cc20_pkg::block_t       init_now;
	cc20_pkg::block_t       init_blk;
	logic [W-1:0]           ctr_sel;
	logic                   slot_free;
	logic                   in_acc;
	logic                   out_load;
	logic                   diag;
	logic                   odd;
	logic [3:0][1:0]        ai, bi, ci, di;
	logic [3:0][W-1:0]      ux, uy, uz, ux_new, uz_new;

	cc20_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	assign slot_free = !out_valid_q || !out_stall;
	assign in_stall  = !((state_q == ST_IDLE) && slot_free);
	assign in_acc    = in_valid && !in_stall;
	assign out_load  = ((state_q == ST_IDLE) && in_acc && (pos_q != 4'd0))
		|| ((state_q == ST_OUT) && slot_free);
	assign ctr_sel   = msg_start_q ? cfg.init_ctr : blk_ctr_q;
	assign init_now  = cc20_pkg::init_state(cfg, ctr_sel);
	assign init_blk  = cc20_pkg::init_state(cfg, ctr_q);

	// column or diagonal lane routing
	assign diag = step_q[2];
	assign odd  = step_q[0];

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			ai[j] = 2'(j);
			bi[j] = diag ? 2'(j + 1) : 2'(j);
			ci[j] = diag ? 2'(j + 2) : 2'(j);
			di[j] = diag ? 2'(j + 3) : 2'(j);
			if (odd) begin
				ux[j] = w_q[{2'd2, ci[j]}];
				uy[j] = w_q[{2'd3, di[j]}];
				uz[j] = w_q[{2'd1, bi[j]}];
			end else begin
				ux[j] = w_q[{2'd0, ai[j]}];
				uy[j] = w_q[{2'd1, bi[j]}];
				uz[j] = w_q[{2'd3, di[j]}];
			end
		end
	end

	cc20_round_unit u_round (
		.step  (step_q[1:0]),
		.x     (ux),
		.y     (uy),
		.z     (uz),
		.x_new (ux_new),
		.z_new (uz_new)
	);

	always_comb begin
		w_rnd = w_q;
		for (int j = 0; j < 4; j++) begin
			if (odd) begin
				w_rnd[{2'd2, ci[j]}] = ux_new[j];
				w_rnd[{2'd1, bi[j]}] = uz_new[j];
			end else begin
				w_rnd[{2'd0, ai[j]}] = ux_new[j];
				w_rnd[{2'd3, di[j]}] = uz_new[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			dr_q        <= '0;
			pos_q       <= '0;
			msg_start_q <= 1'b1;
			blk_ctr_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						pos_q       <= in_item.last_word ? 4'd0 : pos_q + 4'd1;
						msg_start_q <= in_item.last_word;
						if (pos_q == 4'd0) begin
							w_q       <= init_now;
							ctr_q     <= ctr_sel;
							blk_ctr_q <= ctr_sel + 1'b1;
							data_q    <= in_item.data_in;
							last_q    <= in_item.last_word;
							step_q    <= '0;
							dr_q      <= '0;
							state_q   <= ST_ROUND;
						end else begin
							out_item_q.data_out <= in_item.data_in ^ w_q[pos_q];
							out_item_q.last_out <= in_item.last_word;
						end
					end
				end
				ST_ROUND: begin
					w_q    <= w_rnd;
					step_q <= step_q + 3'd1;
					if (step_q == 3'd7) begin
						dr_q <= dr_q + 1'b1;
						if (dr_q == DR_W'(DOUBLE_ROUNDS - 1)) begin
							state_q <= ST_FINAL;
						end
					end
				end
				ST_FINAL: begin
					for (int i = 0; i < 16; i++) begin
						w_q[i] <= w_q[i] + init_blk[i];
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (slot_free) begin
						out_item_q.data_out <= data_q ^ w_q[0];
						out_item_q.last_out <= last_q;
						state_q             <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

endmodule

// ===== hdl/cc20_cfg_regs.sv =====
module cc20_cfg_regs (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [cc20_pkg::CFG_IDX_W-1:0]         cfg_idx,
	input  logic [cc20_pkg::CFG_W-1:0]             cfg_data,
	output cc20_pkg::cfg_t                         cfg
);

	cc20_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				cc20_pkg::REG_KEY_01: begin
					cfg_q.key[1:0] <= cfg_data;
				end
				cc20_pkg::REG_KEY_23: begin
					cfg_q.key[3:2] <= cfg_data;
				end
				cc20_pkg::REG_KEY_45: begin
					cfg_q.key[5:4] <= cfg_data;
				end
				cc20_pkg::REG_KEY_67: begin
					cfg_q.key[7:6] <= cfg_data;
				end
				cc20_pkg::REG_NONCE_01: begin
					cfg_q.nonce[1:0] <= cfg_data;
				end
				cc20_pkg::REG_NONCE_2: begin
					cfg_q.nonce[2] <= cfg_data[cc20_pkg::WORD_W-1:0];
				end
				cc20_pkg::REG_INIT_CTR: begin
					cfg_q.init_ctr <= cfg_data[cc20_pkg::WORD_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hdl/cc20_round_unit.sv =====
module cc20_round_unit (
	input  logic [1:0]                          step,
	input  logic [3:0][cc20_pkg::WORD_W-1:0]    x,
	input  logic [3:0][cc20_pkg::WORD_W-1:0]    y,
	input  logic [3:0][cc20_pkg::WORD_W-1:0]    z,
	output logic [3:0][cc20_pkg::WORD_W-1:0]    x_new,
	output logic [3:0][cc20_pkg::WORD_W-1:0]    z_new
);

	logic [3:0][cc20_pkg::WORD_W-1:0] mix;

	// x += y; z = rotl(z ^ x, r) on four independent lanes
	always_comb begin
		for (int j = 0; j < 4; j++) begin
			x_new[j] = x[j] + y[j];
			mix[j]   = z[j] ^ x_new[j];
			unique case (step)
				2'd0: z_new[j] = {mix[j][15:0], mix[j][31:16]};
				2'd1: z_new[j] = {mix[j][19:0], mix[j][31:20]};
				2'd2: z_new[j] = {mix[j][23:0], mix[j][31:24]};
				2'd3: z_new[j] = {mix[j][24:0], mix[j][31:25]};
				default: z_new[j] = mix[j];
			endcase
		end
	end

endmodule

// ===== hdl/cc20_checker.sv =====
module cc20_checker (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_stall,
	input logic                   out_valid,
	input logic                   out_stall,
	input cc20_pkg::out_item_t    out_item
);

	logic       in_acc;
	logic       out_acc;
	logic [1:0] open_q;

	assign in_acc  = in_valid && !in_stall;
	assign out_acc = out_valid && !out_stall;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else begin
			open_q <= open_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("output transaction changed while stalled");

	a_no_extra_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> open_q != 2'd0)
		else $error("output transaction without a pending input");

	a_one_open: assert property (@(posedge clk) disable iff (!arst_n)
		open_q == 2'd0 || open_q == 2'd1)
		else $error("more than one transaction in flight");

	a_no_take_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !(out_valid && out_stall))
		else $error("input taken while output slot blocked");

endmodule

bind chacha20_stream_xor cc20_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
